// ===== rtl/srp_pkg.sv =====
// Shared types and constants for the splitter range partitioner.
package srp_pkg;

   localparam int SRP_MAX_NODES = 64;

   localparam int KEY_W      = 64;
   localparam int RANK_W     = 6;
   localparam int SLOT_W     = 6;
   localparam int COUNT_W    = 32;
   localparam int NODES_W    = 7;
   localparam int DEST_W     = 6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_RANK   = 1'b1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ROUTE = 1'b1;

   typedef struct packed {
      logic                     cmd;
      logic                     buffer_start;
      logic signed [KEY_W-1:0]  record_key;
      logic [SLOT_W-1:0]        slot;
      logic signed [KEY_W-1:0]  split_key;
      logic [RANK_W-1:0]        split_node;
      logic [COUNT_W-1:0]       split_count;
   } srp_req_type;

   typedef struct packed {
      logic [DEST_W-1:0]        destination;
      logic                     dropped;
      logic [COUNT_W-1:0]       record_number;
   } srp_rsp_type;

   typedef struct packed {
      logic [NODES_W-1:0]       node_count;
      logic [RANK_W-1:0]        own_rank;
   } srp_cfg_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]  key;
      logic [RANK_W-1:0]        node;
      logic [COUNT_W-1:0]       count;
   } srp_splitter_type;

   typedef enum logic [2:0] {
      OP_LOAD  = 3'b001,
      OP_SKIP  = 3'b010,
      OP_ROUTE = 3'b100
   } srp_op_kind_type;

   typedef struct packed {
      srp_op_kind_type          kind;
      logic                     buffer_start;
      logic signed [KEY_W-1:0]  key;
      logic [SLOT_W-1:0]        slot;
      srp_splitter_type         splitter;
   } srp_op_type;

   typedef struct packed {
      logic                     valid;
      srp_op_type               op;
   } srp_head_type;

endpackage

// ===== rtl/srp_front.sv =====
// Front end: accepts items, classifies them and queues them for the engine.
module srp_front import srp_pkg::*; #(
   parameter int MAX_NODES = SRP_MAX_NODES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  srp_req_type   req_data,
   output srp_head_type  head,
   input  logic          pop
);

   srp_op_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                 push;
   srp_op_type           push_op;

   assign req_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   always_comb begin
      push_op.buffer_start      = req_data.buffer_start;
      push_op.key               = req_data.record_key;
      push_op.slot              = req_data.slot;
      push_op.splitter.key      = req_data.split_key;
      push_op.splitter.node     = req_data.split_node;
      push_op.splitter.count    = req_data.split_count;
      if (req_data.cmd == CMD_ROUTE) begin
         push_op.kind = OP_ROUTE;
      end else if (32'(req_data.slot) < 32'(MAX_NODES)) begin
         push_op.kind = OP_LOAD;
      end else begin
         // load beyond the table is turned into a skip here and never written
         push_op.kind = OP_SKIP;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.op    = entries_ff[rd_ptr_ff];

endmodule

// ===== rtl/srp_engine.sv =====
// Back end: splitter table, destination pointer walk and result register.
module srp_engine import srp_pkg::*; #(
   parameter int MAX_NODES = SRP_MAX_NODES
) (
   input  logic          clock,
   input  logic          reset,
   input  srp_cfg_type   cfg,
   input  srp_head_type  head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output srp_rsp_type   rsp_data
);

   localparam int PTR_W = $clog2(MAX_NODES + 1);
   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CMP_W = (PTR_W > NODES_W) ? PTR_W : NODES_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOOK = 2'b10
   } srp_state_type;

   srp_state_type           state_ff, state_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   srp_rsp_type             rsp_data_ff, rsp_data_in;

   srp_splitter_type        mem_ff [MAX_NODES];
   srp_splitter_type        rd_ff;

   logic                    rd_en, wr_en;
   logic [IDX_W-1:0]        rd_addr, wr_addr;
   logic                    out_free;
   logic                    emit;
   srp_rsp_type             emit_data;
   logic [CMP_W-1:0]        in_use;
   logic [PTR_W-1:0]        start_ptr;
   logic [PTR_W-1:0]        ptr_next;
   logic                    beyond;

   always_comb begin
      if (CMP_W'(cfg.node_count) > CMP_W'(MAX_NODES)) begin
         in_use = CMP_W'(MAX_NODES);
      end else begin
         in_use = CMP_W'(cfg.node_count);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign start_ptr = head.op.buffer_start ? '0 : ptr_ff;
   assign ptr_next  = ptr_ff + 1'b1;
   assign wr_addr   = IDX_W'(head.op.slot);

   // lexicographic (key signed, rank, count) compare in one unsigned compare
   assign beyond = {~key_ff[KEY_W-1], key_ff[KEY_W-2:0], cfg.own_rank, count_ff} >
                   {~rd_ff.key[KEY_W-1], rd_ff.key[KEY_W-2:0], rd_ff.node, rd_ff.count};

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      pop       = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      emit      = 1'b0;
      emit_data.destination   = '0;
      emit_data.dropped       = 1'b1;
      emit_data.record_number = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               unique case (head.op.kind)
                  OP_LOAD: begin
                     wr_en = 1'b1;
                     pop   = 1'b1;
                  end
                  OP_SKIP: begin
                     pop = 1'b1;
                  end
                  OP_ROUTE: begin
                     if (CMP_W'(start_ptr) >= in_use) begin
                        if (out_free) begin
                           emit   = 1'b1;
                           ptr_in = start_ptr;
                           pop    = 1'b1;
                        end
                     end else begin
                        ptr_in   = start_ptr;
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(start_ptr);
                        key_in   = head.op.key;
                        pop      = 1'b1;
                        state_in = ST_LOOK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               if (beyond) begin
                  ptr_in = ptr_next;
                  if (CMP_W'(ptr_next) >= in_use) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = IDX_W'(ptr_next);
                  end
               end else begin
                  emit                  = 1'b1;
                  emit_data.destination = DEST_W'(ptr_ff);
                  emit_data.dropped     = 1'b0;
                  count_in              = count_ff + 1'b1;
                  state_in              = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = emit ? emit_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   // splitter table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= head.op.splitter;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/splitter_range_partitioner.sv =====
// Each record walks the splitter table from the destination pointer; its result is registered.
// The engine takes no new load or record until the walk of the current record has ended.
// The pointer walk is bound by the single registered read port of the splitter table.
// A 2-entry queue lets the input side accept while the engine or the result side stalls.
// Reset is synchronous: queue, pointer, record count and result valid clear,
// node_count returns to 1 and own_rank to 0; the splitter table is not cleared.
module splitter_range_partitioner import srp_pkg::*; #(
   parameter int MAX_NODES = SRP_MAX_NODES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  srp_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output srp_rsp_type            rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   srp_cfg_type   cfg_ff, cfg_in;
   srp_head_type  head;
   logic          pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_NODE_COUNT: cfg_in.node_count = NODES_W'(csr_wdata);
            CSR_OWN_RANK:   cfg_in.own_rank   = csr_wdata[RANK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count <= NODES_W'(1);
         cfg_ff.own_rank   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srp_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   srp_engine #(
      .MAX_NODES (MAX_NODES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/srp_checker.sv =====
// Port-level checks for the splitter range partitioner, bound to the top level.
module srp_checker import srp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  srp_rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   a_drop_dest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dropped) |-> (rsp_data.destination == '0))
      else $error("dropped item carries a nonzero destination");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind splitter_range_partitioner srp_checker u_srp_checker (.*);

// ===== bench/splitter_range_partitioner_tb.sv =====
// Self-checking testbench for the splitter range partitioner: splitter loads, record routing, CSR sweeps.
module splitter_range_partitioner_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srp_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 80;   // full 64-splitter walk plus pipeline
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   class route_scoreboard;
      logic signed [KEY_W-1:0] bound_key   [SRP_MAX_NODES];
      logic [RANK_W-1:0]       bound_node  [SRP_MAX_NODES];
      logic [COUNT_W-1:0]      bound_count [SRP_MAX_NODES];
      int unsigned             dest_ptr;
      logic [COUNT_W-1:0]      routed;
      logic [NODES_W-1:0]      nodes_cfg;
      logic [RANK_W-1:0]       rank_cfg;
      srp_rsp_type             routes_due[$];
      int                      errors;

      function new();
         dest_ptr  = 0;
         routed    = '0;
         nodes_cfg = NODES_W'(1);
         rank_cfg  = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_NODE_COUNT: nodes_cfg = val[NODES_W-1:0];
            CSR_OWN_RANK:   rank_cfg  = val[RANK_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_item(srp_req_type item);
         logic signed [KEY_W-1:0] key;
         int unsigned             in_use;
         bit                      beyond;
         srp_rsp_type             want;
         if (item.cmd == CMD_LOAD) begin
            bound_key[item.slot]   = item.split_key;
            bound_node[item.slot]  = item.split_node;
            bound_count[item.slot] = item.split_count;
            return;
         end
         key    = item.record_key;
         in_use = (nodes_cfg > SRP_MAX_NODES) ? SRP_MAX_NODES : nodes_cfg;
         if (item.buffer_start)
            dest_ptr = 0;
         // lexicographic (key, rank, count) against the current splitter
         while (dest_ptr < in_use) begin
            if (key != bound_key[dest_ptr])
               beyond = key > bound_key[dest_ptr];
            else if (rank_cfg != bound_node[dest_ptr])
               beyond = rank_cfg > bound_node[dest_ptr];
            else
               beyond = routed > bound_count[dest_ptr];
            if (!beyond)
               break;
            dest_ptr++;
         end
         want.record_number = routed;
         if (dest_ptr >= in_use) begin
            want.destination = '0;
            want.dropped     = 1'b1;
         end else begin
            want.destination = DEST_W'(dest_ptr);
            want.dropped     = 1'b0;
            routed++;
         end
         routes_due.push_back(want);
      endfunction

      function void check_result(srp_rsp_type got);
         srp_rsp_type want;
         if (routes_due.size() == 0) begin
            $display("%0t: result with nothing expected: dest %0d dropped %0d number %0d",
                     $time, got.destination, got.dropped, got.record_number);
            errors++;
            return;
         end
         want = routes_due.pop_front();
         if (got.destination !== want.destination) begin
            $display("%0t: destination expected %0d actual %0d",
                     $time, want.destination, got.destination);
            errors++;
         end
         if (got.dropped !== want.dropped) begin
            $display("%0t: dropped expected %0d actual %0d", $time, want.dropped, got.dropped);
            errors++;
         end
         if (got.record_number !== want.record_number) begin
            $display("%0t: record_number expected %0d actual %0d",
                     $time, want.record_number, got.record_number);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   srp_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   srp_rsp_type           rsp_data;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   route_scoreboard         sb = new();
   logic signed [KEY_W-1:0] guide_key [SRP_MAX_NODES];
   bit                      send_idle_on;
   bit                      recv_idle_on;
   bit                      long_hold_pending;
   int                      quiet_cycles;

   splitter_range_partitioner u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stall bursts, one long hold on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (recv_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic srp_req_type make_load(int slot, logic signed [KEY_W-1:0] key,
                                             logic [RANK_W-1:0] node,
                                             logic [COUNT_W-1:0] count);
      srp_req_type item;
      item.cmd          = CMD_LOAD;
      item.buffer_start = 1'($urandom_range(0, 1));
      item.record_key   = {$urandom, $urandom};
      item.slot         = SLOT_W'(slot);
      item.split_key    = key;
      item.split_node   = node;
      item.split_count  = count;
      return item;
   endfunction

   function automatic srp_req_type make_route(bit first, logic signed [KEY_W-1:0] key);
      srp_req_type item;
      item = make_load($urandom_range(0, 63), {$urandom, $urandom}, RANK_W'($urandom),
                       $urandom);
      item.cmd          = CMD_ROUTE;
      item.buffer_start = first;
      item.record_key   = key;
      return item;
   endfunction

   task automatic send_item(srp_req_type item);
      if (send_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_item(item);
   endtask

   // loads produce no result, so let the engine settle before touching CSRs
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.routes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [NODES_W-1:0] nodes, logic [RANK_W-1:0] rank);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_NODE_COUNT;
      csr_wdata    <= CSR_DATA_W'(nodes);
      @(posedge clock);
      sb.write_reg(CSR_NODE_COUNT, CSR_DATA_W'(nodes));
      csr_index    <= CSR_OWN_RANK;
      csr_wdata    <= CSR_DATA_W'(rank);
      @(posedge clock);
      sb.write_reg(CSR_OWN_RANK, CSR_DATA_W'(rank));
      csr_write_en <= 1'b0;
   endtask

   // ascending splitter keys with duplicates; nodes and counts near the tie points
   task automatic build_table();
      logic signed [KEY_W-1:0] key;
      logic [RANK_W-1:0]       node;
      logic [COUNT_W-1:0]      count;
      key = $signed({$urandom, $urandom}) >>> 2;
      for (int i = 0; i < SRP_MAX_NODES; i++) begin
         if ($urandom_range(0, 3) != 0)
            key = key + $urandom_range(1, 2000);
         case ($urandom_range(0, 3))
            0:       node = sb.rank_cfg;
            1:       node = sb.rank_cfg + 1'b1;
            2:       node = sb.rank_cfg - 1'b1;
            default: node = RANK_W'($urandom);
         endcase
         count = ($urandom_range(0, 7) == 0) ? $urandom : sb.routed + $urandom_range(0, 200);
         guide_key[i] = key;
         send_item(make_load(i, key, node, count));
      end
   endtask

   // one buffer of sorted keys, often landing exactly on splitter keys
   task automatic send_buffer(int span);
      logic signed [KEY_W-1:0] key;
      int                      p;
      int                      len;
      p   = $urandom_range(0, span - 1);
      key = guide_key[p] - $urandom_range(0, 3000);
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(0, 3))
            1: begin
               if (p < SRP_MAX_NODES - 1 && $urandom_range(0, 1) == 1)
                  p++;
               if (guide_key[p] > key)
                  key = guide_key[p];
            end
            2, 3: key = key + $urandom_range(1, 1500);
            default: ;
         endcase
         send_item(make_route(k == 0 ? ($urandom_range(0, 7) != 0) : 1'b0, key));
      end
   endtask

   task automatic run_phase(logic [NODES_W-1:0] nodes, logic [RANK_W-1:0] rank,
                            bit send_idle, bit recv_idle, bit hold);
      int span;
      drain();
      send_idle_on = send_idle;
      recv_idle_on = recv_idle;
      set_config(nodes, rank);
      if (hold)
         long_hold_pending = 1'b1;
      build_table();
      span = (nodes == 0 || nodes > SRP_MAX_NODES) ? SRP_MAX_NODES : nodes;
      for (int b = 0; b < 16; b++) begin
         if ($urandom_range(0, 7) != 0)
            send_buffer(span);
         else if ($urandom_range(0, 1) == 1)
            send_item(make_load($urandom_range(0, 63), {$urandom, $urandom},
                                RANK_W'($urandom), $urandom));
         else
            send_item(make_route(1'($urandom_range(0, 1)), {$urandom, $urandom}));
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: ties on each part of the triple, key extremes, drop and buffer restart
      set_config(NODES_W'(4), RANK_W'(10));
      send_item(make_load(0, -64'sd100, RANK_W'(10), 32'd1));
      send_item(make_load(1, 64'sd0, RANK_W'(63), 32'd0));
      send_item(make_load(2, 64'sd0, RANK_W'(0), 32'hFFFF_FFFF));
      send_item(make_load(3, KEY_MAX, RANK_W'(10), 32'hFFFF_FFFF));
      send_item(make_load(63, KEY_MIN, RANK_W'(0), 32'd0));
      send_item(make_route(1'b1, KEY_MIN));
      send_item(make_route(1'b0, -64'sd100));
      send_item(make_route(1'b0, -64'sd100));
      send_item(make_route(1'b0, 64'sd0));
      send_item(make_route(1'b0, 64'sd1));
      send_item(make_route(1'b0, KEY_MAX));
      send_item(make_route(1'b1, 64'sd0));
      send_item(make_load(3, 64'sd5, RANK_W'(10), 32'd0));
      send_item(make_route(1'b1, 64'sd6));
      send_item(make_route(1'b0, 64'sd7));
      send_item(make_route(1'b1, KEY_MIN));

      run_phase(NODES_W'(64), RANK_W'(0), 1'b1, 1'b1, 1'b0);
      run_phase(NODES_W'(1), RANK_W'(63), 1'b1, 1'b0, 1'b0);
      run_phase(NODES_W'(0), RANK_W'($urandom), 1'b0, 1'b1, 1'b0);
      run_phase(NODES_W'(127), RANK_W'($urandom), 1'b1, 1'b1, 1'b1);
      for (int ph = 0; ph < 5; ph++)
         run_phase(NODES_W'($urandom_range(1, 64)), RANK_W'($urandom),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
      run_phase(NODES_W'($urandom_range(1, 64)), RANK_W'($urandom), 1'b0, 1'b0, 1'b0);

      drain();
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== splitter_range_partitioner.f =====
rtl/srp_pkg.sv
rtl/srp_front.sv
rtl/srp_engine.sv
rtl/splitter_range_partitioner.sv
rtl/srp_checker.sv
bench/splitter_range_partitioner_tb.sv
